/* hw/rtl/bitmap_block_allocator_top_macros.svh */
// Assertion macros shared by the allocator modules.
// Each macro expands to a labeled concurrent assertion in simulation and
// to nothing in synthesis.
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BBA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitmap allocator check failed");
// Next-cycle implication.
`define BBA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitmap allocator check failed");
`else
`define BBA_ASSERT_IMP(label, clk, rst, ante, cons)
`define BBA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/bba_pkg.sv */
`timescale 1ns / 1ps

package bba_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_GROUP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_TOTAL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_BLOCK = 2'd2;

  localparam logic [13:0] RST_BLOCKS_PER_GROUP = 14'd8192;
  localparam logic [17:0] RST_BLOCKS_TOTAL     = 18'd131072;
  localparam logic        RST_FIRST_DATA_BLOCK = 1'b1;

  localparam logic [1:0] REQ_LOAD_BYTE  = 2'd0;
  localparam logic [1:0] REQ_ALLOCATE   = 2'd1;
  localparam logic [1:0] REQ_LOAD_COUNT = 2'd2;

  localparam logic [1:0] ST_LOAD_DONE = 2'd0;
  localparam logic [1:0] ST_ALLOCATED = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;

  localparam logic [7:0] FULL_BYTE = 8'hff;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  group_index;
    logic [9:0]  byte_index;
    logic [17:0] load_value;
    logic        count_is_total;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] block_number;
    logic [17:0] free_total;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GROUP,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic take_in;
    logic do_load;
    logic scan_start;
    logic group_next;
    logic byte_next;
    logic commit;
    logic set_nospace;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       group_ok;
    logic       byte_found;
    logic       last_byte;
    logic       out_busy;
  } sts_t;

endpackage

/* hw/rtl/bitmap_block_allocator_top.sv */
`timescale 1ns / 1ps
// Block allocator over per-group block bitmaps with per-group and total
// free counts. Input words load a bitmap byte, a group or total free count,
// or request one block; every input word yields exactly one output word
// (status, block number, total free count after the word).
// Channels: in_valid/in_stall/in_word and out_valid/out_stall/out_word; a
// word moves at a clock edge with valid high and stall low. Configuration
// registers (blocks per group, blocks total, first data block) are written
// through cfg_write/cfg_index/cfg_data; the user must write them only while
// the block is idle, which the block itself does not enforce. A load word
// passes EXEC and FINISH to the output register; an allocate word passes
// EXEC, a GROUP state per group check (a final failing one included), a
// READ and a CHECK state per bitmap byte examined, and FINISH. The bitmap
// RAM has a registered read, hence READ before CHECK. One word at a time:
// the next is accepted in the cycle after the output register is loaded.
// Reset clears the configuration to its defaults, the total free count to 0
// and both handshakes; bitmap RAM and group counts are undefined until
// loaded. A stalled result holds in the output register, and a following
// result waits until that slot frees.
module bitmap_block_allocator_top #(
  parameter int GROUPS          = 16,
  parameter int BYTES_PER_GROUP = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bba_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bba_pkg::out_word_t             out_word,
  input  logic                           cfg_write,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  // sequencer: accept, dispatch, walk groups and bytes, hand off result
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, scan counters, first-clear-bit search and output register
  bba_datapath #(
    .GROUPS          (GROUPS),
    .BYTES_PER_GROUP (BYTES_PER_GROUP)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* hw/rtl/bba_ctrl.sv */
`timescale 1ns / 1ps
`include "bitmap_block_allocator_top_macros.svh"

module bba_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  bba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      bba_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = bba_pkg::S_EXEC;
        end
      end
      bba_pkg::S_EXEC: begin
        if (sts.req_type == bba_pkg::REQ_ALLOCATE) begin
          cmd.scan_start = 1'b1;
          state_next     = bba_pkg::S_GROUP;
        end else begin
          cmd.do_load = 1'b1;
          state_next  = bba_pkg::S_FINISH;
        end
      end
      bba_pkg::S_GROUP: begin
        if (sts.group_ok) begin
          state_next = bba_pkg::S_READ;
        end else begin
          cmd.set_nospace = 1'b1;
          state_next      = bba_pkg::S_FINISH;
        end
      end
      bba_pkg::S_READ: begin
        state_next = bba_pkg::S_CHECK;
      end
      bba_pkg::S_CHECK: begin
        priority if (sts.byte_found) begin
          cmd.commit = 1'b1;
          state_next = bba_pkg::S_FINISH;
        end else if (sts.last_byte) begin
          cmd.group_next = 1'b1;
          state_next     = bba_pkg::S_GROUP;
        end else begin
          cmd.byte_next = 1'b1;
          state_next    = bba_pkg::S_READ;
        end
      end
      bba_pkg::S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bba_pkg::S_IDLE;
      end
    endcase
  end

  `BBA_ASSERT_IMP(a_one_cmd, clk, rst, 1'b1, $onehot0({cmd.take_in, cmd.do_load, cmd.scan_start, cmd.group_next, cmd.byte_next, cmd.commit, cmd.set_nospace, cmd.out_load}))
  `BBA_ASSERT_IMP(a_commit_in_range, clk, rst, cmd.commit, sts.group_ok)

endmodule

/* hw/rtl/bba_datapath.sv */
`timescale 1ns / 1ps
`include "bitmap_block_allocator_top_macros.svh"

module bba_datapath #(
  parameter int GROUPS          = 16,
  parameter int BYTES_PER_GROUP = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bba_pkg::cmd_t                     cmd,
  output bba_pkg::sts_t                     sts,
  input  bba_pkg::in_word_t                 in_word,
  input  logic                              cfg_write,
  input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bba_pkg::out_word_t                out_word
);

  localparam int GW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int KW        = $clog2(BYTES_PER_GROUP);
  localparam int AW        = $clog2(GROUPS * BYTES_PER_GROUP);
  localparam int BASE_W    = GW + 15;
  localparam int DEPTH     = GROUPS * BYTES_PER_GROUP;
  localparam int LIMIT_MAX = BYTES_PER_GROUP * 8;

  // configuration
  logic [13:0] blocks_per_group;
  logic [17:0] blocks_total;
  logic        first_data_block;

  bba_pkg::in_word_t req;

  // scan position
  logic [GW:0]       gc;
  logic [BASE_W-1:0] base;
  logic [AW-1:0]     gaddr;
  logic [KW-1:0]     k;

  logic [17:0] total_free;
  logic [1:0]  res_status;
  logic [17:0] res_block;

  // stores
  logic [7:0]  bitmap [DEPTH];
  logic [13:0] gfree  [GROUPS];
  logic [7:0]  rd_data;
  logic [13:0] gcnt;

  logic [13:0]   limit;
  logic [GW-1:0] gidx;
  logic [AW-1:0] rd_addr;
  logic [7:0]    valid_mask;
  logic [7:0]    free_bits;
  logic [2:0]    found_bit;
  logic          group_ok;
  logic          byte_found;
  logic          last_byte;
  logic          grp_in_range;
  logic          byte_in_range;

  logic          bm_we;
  logic [AW-1:0] bm_waddr;
  logic [7:0]    bm_wdata;
  logic          gf_we;
  logic [GW-1:0] gf_waddr;
  logic [13:0]   gf_wdata;

  always_comb begin
    limit = (32'(blocks_per_group) > LIMIT_MAX) ? 14'(LIMIT_MAX) : blocks_per_group;
    gidx  = gc[GW-1:0];
    rd_addr = gaddr + AW'(k);
    group_ok = (32'(gc) < GROUPS) && (32'(base) < 32'(blocks_total))
               && (blocks_per_group != 14'd0);
    for (int j = 0; j < 8; j++) begin
      valid_mask[j] = 32'({k, 3'(j)}) < 32'(limit);
    end
    free_bits  = ~rd_data & valid_mask;
    byte_found = |free_bits;
    found_bit  = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (free_bits[j]) begin
        found_bit = 3'(j);
      end
    end
    last_byte     = ((32'(k) << 3) + 32'd8) >= 32'(limit);
    grp_in_range  = 32'(req.group_index) < GROUPS;
    byte_in_range = 32'(req.byte_index) < BYTES_PER_GROUP;
  end

  assign sts.req_type   = req.req_type;
  assign sts.group_ok   = group_ok;
  assign sts.byte_found = byte_found;
  assign sts.last_byte  = last_byte;
  assign sts.out_busy   = out_valid && out_stall;

  // write port selection for both stores
  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = rd_addr;
    bm_wdata = rd_data | (8'd1 << found_bit);
    gf_we    = 1'b0;
    gf_waddr = gidx;
    gf_wdata = gcnt - 14'(gcnt != 14'd0);
    if (cmd.commit) begin
      bm_we = 1'b1;
      gf_we = 1'b1;
    end else if (cmd.do_load) begin
      bm_waddr = AW'(32'(req.group_index) * BYTES_PER_GROUP + 32'(req.byte_index));
      bm_wdata = req.load_value[7:0];
      gf_waddr = GW'(req.group_index);
      gf_wdata = req.load_value[13:0];
      bm_we    = (req.req_type == bba_pkg::REQ_LOAD_BYTE) && grp_in_range && byte_in_range;
      gf_we    = (req.req_type == bba_pkg::REQ_LOAD_COUNT) && !req.count_is_total
                 && grp_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bitmap[bm_waddr] <= bm_wdata;
    end
    rd_data <= bitmap[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (gf_we) begin
      gfree[gf_waddr] <= gf_wdata;
    end
    gcnt <= gfree[gidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocks_per_group <= bba_pkg::RST_BLOCKS_PER_GROUP;
      blocks_total     <= bba_pkg::RST_BLOCKS_TOTAL;
      first_data_block <= bba_pkg::RST_FIRST_DATA_BLOCK;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bba_pkg::CFG_BLOCKS_PER_GROUP: blocks_per_group <= cfg_data[13:0];
        bba_pkg::CFG_BLOCKS_TOTAL:     blocks_total     <= cfg_data[17:0];
        bba_pkg::CFG_FIRST_DATA_BLOCK: first_data_block <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_free <= '0;
    end else if (cmd.do_load && req.req_type == bba_pkg::REQ_LOAD_COUNT && req.count_is_total) begin
      total_free <= req.load_value;
    end else if (cmd.commit && total_free != 18'd0) begin
      total_free <= total_free - 18'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      req <= in_word;
    end
    if (cmd.scan_start) begin
      gc    <= '0;
      base  <= '0;
      gaddr <= '0;
      k     <= '0;
    end else if (cmd.group_next) begin
      gc    <= gc + 1'b1;
      base  <= base + BASE_W'(blocks_per_group);
      gaddr <= gaddr + AW'(BYTES_PER_GROUP);
      k     <= '0;
    end else if (cmd.byte_next) begin
      k <= k + 1'b1;
    end
    if (cmd.do_load || cmd.set_nospace) begin
      res_status <= cmd.do_load ? bba_pkg::ST_LOAD_DONE : bba_pkg::ST_NO_SPACE;
      res_block  <= '0;
    end else if (cmd.commit) begin
      res_status <= bba_pkg::ST_ALLOCATED;
      res_block  <= 18'(base + BASE_W'({k, found_bit}) + BASE_W'(first_data_block));
    end
  end

  // output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.status       <= res_status;
      out_word.block_number <= res_block;
      out_word.free_total   <= total_free;
    end
  end

  `BBA_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !(out_valid && out_stall))
  `BBA_ASSERT_IMP(a_rise_from_load, clk, rst, $rose(out_valid), $past(cmd.out_load))
  `BBA_ASSERT_NXT(a_total_only_falls, clk, rst, !cmd.do_load, total_free <= $past(total_free))
  `BBA_ASSERT_IMP(a_commit_clear_bit, clk, rst, cmd.commit, byte_found && !rd_data[found_bit])

endmodule
